[src/isg_pkg.sv]
package isg_pkg;

    // Default saturation limits
    localparam int ISG_MAX_SIDE     = 256;
    localparam int ISG_MAX_CHANNELS = 512;
    localparam int ISG_MAX_KERNEL   = 15;

    // Field widths
    localparam int ROW_W     = 8;
    localparam int COL_W     = 8;
    localparam int DEST_W    = 33;
    localparam int SRC_W     = 25;
    localparam int CNT_W     = 13;
    localparam int HEIGHT_W  = 9;
    localparam int WIDTH_W   = 9;
    localparam int CHAN_W    = 10;
    localparam int KERN_W    = 4;
    localparam int SMALL_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    // Shared multiplier operand widths
    localparam int MUL_A_W = SRC_W;
    localparam int MUL_B_W = CHAN_W;

    // Stream word widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 104;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_HEIGHT     = 3'd0,
        REG_IN_WIDTH      = 3'd1,
        REG_CHANNELS      = 3'd2,
        REG_KERNEL_HEIGHT = 3'd3,
        REG_KERNEL_WIDTH  = 3'd4,
        REG_PAD           = 3'd5,
        REG_STRIDE        = 3'd6
    } cfg_reg_t;

    // Saturated configuration as seen by the sequencer
    typedef struct packed {
        logic [HEIGHT_W-1:0] in_height;
        logic [WIDTH_W-1:0]  in_width;
        logic [CHAN_W-1:0]   channels;
        logic [KERN_W-1:0]   kernel_height;
        logic [KERN_W-1:0]   kernel_width;
        logic [SMALL_W-1:0]  pad;
        logic [SMALL_W-1:0]  stride;
    } isg_cfg_t;

endpackage

[src/im2col_nhwc_segment_generator_core.sv]
// im2col segment generator for NHWC feature maps.
//
// Input stream (s_): one word per output pixel; tdata holds out_row and
// out_col, tuser holds restart, which zeroes the running destination offset
// before the pixel is processed. Output stream (m_): one copy descriptor per
// kernel row, tlast marks the final row of a pixel.
// Configuration channel (cfg_): register index plus data, always ready;
// write only while the block is idle.
//
// Sequencing: after the accepting edge the block runs ten setup steps,
// M0 to M9, then emits the first descriptor of the pixel, followed by one
// descriptor per cycle while the receiver takes them. The setup is bound
// by the single shared multiplier, which forms nine products per pixel one
// after the other. Source addresses of later rows are stepped by addition.
//
// s_tready is high only while no pixel is in progress. The last descriptor
// sits in an output register, so the next pixel is accepted while it waits.
// A stalled receiver holds the descriptor and pauses the row walk.
// Reset restores the default configuration, clears the running destination
// offset and drops the output valid flag.
module im2col_nhwc_segment_generator_core import isg_pkg::*; #(
    parameter int MAX_SIDE     = ISG_MAX_SIDE,
    parameter int MAX_CHANNELS = ISG_MAX_CHANNELS,
    parameter int MAX_KERNEL   = ISG_MAX_KERNEL
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    // Pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [7:0] out_row, [15:8] out_col
    input  logic                 s_tuser,   // [0] restart
    // Descriptor output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [32:0] dest_offset,
                                            // [57:33] source_address,
                                            // [70:58] lead_zeros,
                                            // [83:71] data_count,
                                            // [96:84] trail_zeros, rest 0
    output logic                 m_tlast    // last
);

    localparam int POS_W = 14;  // signed pixel coordinate width

    typedef enum logic [3:0] {
        ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_M6, ST_M7, ST_M8, ST_M9, ST_EMIT
    } state_t;

    isg_cfg_t cfg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_A_W-1:0] mul_p;

    state_t state_reg, state_next;
    logic [ROW_W-1:0]  orow_reg, orow_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [DEST_W-1:0] dest_reg, dest_next;
    logic [KERN_W-1:0] k_reg, k_next;
    logic signed [POS_W-1:0] col0_reg, col0_next;
    logic signed [POS_W-1:0] col1_reg, col1_next;
    logic signed [POS_W-1:0] lo_reg, lo_next;
    logic signed [POS_W-1:0] hi_reg, hi_next;
    logic colok_reg, colok_next;
    logic signed [POS_W-1:0] row_reg, row_next;
    logic [CNT_W:0]    seg_reg, seg_next;
    logic [CNT_W-1:0]  lead_reg, lead_next;
    logic [CNT_W-1:0]  data_reg, data_next;
    logic [CNT_W-1:0]  trail_reg, trail_next;
    logic [SRC_W-1:0]  wc_reg, wc_next;
    logic [SRC_W-1:0]  src_reg, src_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_tlast_reg, m_tlast_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic signed [POS_W-1:0] pos_c, col1_c, lo_c, hi_c, w_pos;
    logic signed [POS_W-1:0] lead_span, data_span, trail_span;
    logic              out_free, row_ok, seg_ok, emit_fire;
    logic [SRC_W-1:0]  out_src;
    logic [CNT_W-1:0]  out_lead, out_data, out_trail;

    isg_cfg #(
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    isg_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // Coordinate from a position product: pos*stride - pad
    assign pos_c  = signed'({1'b0, mul_p[POS_W-2:0]}) -
                    signed'({{(POS_W-SMALL_W){1'b0}}, cfg.pad});
    assign col1_c = pos_c + signed'({{(POS_W-KERN_W){1'b0}}, cfg.kernel_width});
    assign w_pos  = signed'({{(POS_W-WIDTH_W){1'b0}}, cfg.in_width});
    assign lo_c   = pos_c[POS_W-1] ? '0 : pos_c;
    assign hi_c   = (col1_c > w_pos) ? w_pos : col1_c;

    assign lead_span  = lo_reg - col0_reg;
    assign data_span  = hi_reg - lo_reg;
    assign trail_span = col1_reg - hi_reg;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M0: begin
                mul_a = MUL_A_W'(ocol_reg);
                mul_b = MUL_B_W'(cfg.stride);
            end
            ST_M1: begin
                mul_a = MUL_A_W'(orow_reg);
                mul_b = MUL_B_W'(cfg.stride);
            end
            ST_M2: begin
                mul_a = MUL_A_W'(cfg.kernel_width);
                mul_b = cfg.channels;
            end
            ST_M3: begin
                mul_a = {{(MUL_A_W-POS_W){lead_span[POS_W-1]}}, lead_span};
                mul_b = cfg.channels;
            end
            ST_M4: begin
                mul_a = {{(MUL_A_W-POS_W){data_span[POS_W-1]}}, data_span};
                mul_b = cfg.channels;
            end
            ST_M5: begin
                mul_a = {{(MUL_A_W-POS_W){trail_span[POS_W-1]}}, trail_span};
                mul_b = cfg.channels;
            end
            ST_M6: begin
                mul_a = MUL_A_W'(cfg.in_width);
                mul_b = cfg.channels;
            end
            ST_M7: begin
                mul_a = {{(MUL_A_W-POS_W){row_reg[POS_W-1]}}, row_reg};
                mul_b = MUL_B_W'(cfg.in_width);
            end
            ST_M8: begin
                // first-row pixel index plus left column, times channels
                mul_a = mul_p + {{(MUL_A_W-POS_W){1'b0}}, lo_reg};
                mul_b = cfg.channels;
            end
            default: ;
        endcase
    end

    // Descriptor fields for the current kernel row
    assign row_ok = !row_reg[POS_W-1] &&
                    (row_reg < signed'({{(POS_W-HEIGHT_W){1'b0}}, cfg.in_height}));
    assign seg_ok    = row_ok && colok_reg;
    assign out_src   = seg_ok ? src_reg : '0;
    assign out_lead  = seg_ok ? lead_reg : seg_reg[CNT_W-1:0];
    assign out_data  = seg_ok ? data_reg : '0;
    assign out_trail = seg_ok ? trail_reg : '0;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        dest_next     = dest_reg;
        k_next        = k_reg;
        col0_next     = col0_reg;
        col1_next     = col1_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        colok_next    = colok_reg;
        row_next      = row_reg;
        seg_next      = seg_reg;
        lead_next     = lead_reg;
        data_next     = data_reg;
        trail_next    = trail_reg;
        wc_next       = wc_reg;
        src_next      = src_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    orow_next  = s_tdata[ROW_W-1:0];
                    ocol_next  = s_tdata[ROW_W+COL_W-1:ROW_W];
                    k_next     = '0;
                    if (s_tuser) begin
                        dest_next = '0;
                    end
                    state_next = ST_M0;
                end
            end
            ST_M0: state_next = ST_M1;
            ST_M1: begin
                col0_next  = pos_c;
                col1_next  = col1_c;
                lo_next    = lo_c;
                hi_next    = hi_c;
                colok_next = hi_c > lo_c;
                state_next = ST_M2;
            end
            ST_M2: begin
                row_next   = pos_c;
                state_next = ST_M3;
            end
            ST_M3: begin
                seg_next   = mul_p[CNT_W:0];
                state_next = ST_M4;
            end
            ST_M4: begin
                lead_next  = mul_p[CNT_W-1:0];
                state_next = ST_M5;
            end
            ST_M5: begin
                data_next  = mul_p[CNT_W-1:0];
                state_next = ST_M6;
            end
            ST_M6: begin
                trail_next = mul_p[CNT_W-1:0];
                state_next = ST_M7;
            end
            ST_M7: begin
                wc_next    = mul_p;
                state_next = ST_M8;
            end
            ST_M8: state_next = ST_M9;
            ST_M9: begin
                src_next   = mul_p;
                state_next = (cfg.kernel_height == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (k_reg == cfg.kernel_height - KERN_W'(1));
                    m_tdata_next  = {{(M_DATA_W-DEST_W-SRC_W-3*CNT_W){1'b0}},
                                     out_trail, out_data, out_lead, out_src, dest_reg};
                    dest_next = dest_reg + {{(DEST_W-CNT_W-1){1'b0}}, seg_reg};
                    src_next  = src_reg + wc_reg;
                    row_next  = row_reg + POS_W'(1);
                    k_next    = k_reg + KERN_W'(1);
                    if (k_reg == cfg.kernel_height - KERN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dest_reg     <= '0;
            k_reg        <= '0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dest_reg     <= dest_next;
            k_reg        <= k_next;
            orow_reg     <= orow_next;
            ocol_reg     <= ocol_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        col0_reg    <= col0_next;
        col1_reg    <= col1_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        colok_reg   <= colok_next;
        row_reg     <= row_next;
        seg_reg     <= seg_next;
        lead_reg    <= lead_next;
        data_reg    <= data_next;
        trail_reg   <= trail_next;
        wc_reg      <= wc_next;
        src_reg     <= src_next;
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    // One pixel at a time: no second word right after an accepted one
    a_one_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Row walk never runs past the kernel height
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> k_reg < cfg.kernel_height)
        else $error("kernel row count past kernel height");

    // Zeros and data of every descriptor fill exactly one segment
    a_seg_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> CNT_W'(m_tdata[70:58] + m_tdata[83:71] + m_tdata[96:84])
                      == $past(seg_reg[CNT_W-1:0]))
        else $error("descriptor counts do not add up to the segment");

    // No copied data means no source address
    a_src_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[83:71] == '0) |-> m_tdata[57:33] == '0)
        else $error("source address without copied data");

    // Last flag on the word that ends the row walk, with input ready again
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire && (k_reg == cfg.kernel_height - KERN_W'(1)) |=>
            m_tlast && s_tready)
        else $error("last flag out of step with the row walk");

endmodule

[src/isg_cfg.sv]
module isg_cfg import isg_pkg::*; #(
    parameter int MAX_SIDE     = ISG_MAX_SIDE,
    parameter int MAX_CHANNELS = ISG_MAX_CHANNELS,
    parameter int MAX_KERNEL   = ISG_MAX_KERNEL
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output isg_cfg_t             cfg
);

    logic [HEIGHT_W-1:0] in_height_reg;
    logic [WIDTH_W-1:0]  in_width_reg;
    logic [CHAN_W-1:0]   channels_reg;
    logic [KERN_W-1:0]   kernel_height_reg;
    logic [KERN_W-1:0]   kernel_width_reg;
    logic [SMALL_W-1:0]  pad_reg;
    logic [SMALL_W-1:0]  stride_reg;

    assign cfg_ready = 1'b1;

    // Register file, writes masked to each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_height_reg     <= HEIGHT_W'(1);
            in_width_reg      <= WIDTH_W'(1);
            channels_reg      <= CHAN_W'(1);
            kernel_height_reg <= KERN_W'(1);
            kernel_width_reg  <= KERN_W'(1);
            pad_reg           <= '0;
            stride_reg        <= SMALL_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_IN_HEIGHT:     in_height_reg     <= cfg_data[HEIGHT_W-1:0];
                REG_IN_WIDTH:      in_width_reg      <= cfg_data[WIDTH_W-1:0];
                REG_CHANNELS:      channels_reg      <= cfg_data[CHAN_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[KERN_W-1:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[KERN_W-1:0];
                REG_PAD:           pad_reg           <= cfg_data[SMALL_W-1:0];
                REG_STRIDE:        stride_reg        <= cfg_data[SMALL_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate oversized sizes and kernel settings to the build limits; pad and stride pass through
    always_comb begin
        cfg.in_height = (32'(in_height_reg) > MAX_SIDE) ?
                        HEIGHT_W'(MAX_SIDE) : in_height_reg;
        cfg.in_width  = (32'(in_width_reg) > MAX_SIDE) ?
                        WIDTH_W'(MAX_SIDE) : in_width_reg;
        cfg.channels  = (32'(channels_reg) > MAX_CHANNELS) ?
                        CHAN_W'(MAX_CHANNELS) : channels_reg;
        cfg.kernel_height = (32'(kernel_height_reg) > MAX_KERNEL) ?
                            KERN_W'(MAX_KERNEL) : kernel_height_reg;
        cfg.kernel_width  = (32'(kernel_width_reg) > MAX_KERNEL) ?
                            KERN_W'(MAX_KERNEL) : kernel_width_reg;
        cfg.pad    = pad_reg;
        cfg.stride = stride_reg;
    end

endmodule

[src/isg_mul.sv]
module isg_mul import isg_pkg::*; (
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [MUL_A_W-1:0] prod
);

    logic [MUL_A_W+MUL_B_W-1:0] full;
    logic [MUL_A_W-1:0]         prod_reg;

    // Product modulo 2^MUL_A_W; a two's complement op_a wraps correctly
    assign full = {{MUL_B_W{1'b0}}, op_a} * {{MUL_A_W{1'b0}}, op_b};

    always_ff @(posedge aclk) begin
        prod_reg <= full[MUL_A_W-1:0];
    end

    assign prod = prod_reg;

endmodule
